// ===== design/mpe_pkg.sv =====
package mpe_pkg;

	// Fixed view geometry
	localparam int unsigned IMAGE_WIDTH  = 320;
	localparam int unsigned IMAGE_HEIGHT = 240;

	// Q32.32 constants
	localparam logic [63:0] RECIP_WIDTH_Q = 64'h0000_0000_00CC_CCCD;
	localparam logic [63:0] HALF_Q        = 64'h0000_0000_8000_0000;
	localparam logic [63:0] HALF_HEIGHT_Q = 64'(IMAGE_HEIGHT / 2) << 32;

	localparam int unsigned COUNT_W      = 9;
	localparam int unsigned COLOR_W      = 8;
	localparam logic [COUNT_W-1:0] PALETTE_SPAN = 9'd255;
	localparam logic [31:0] ESCAPE_BOUND = 32'd4;

	// Register reset values
	localparam logic signed [63:0] CENTER_REAL_RST = -64'sd3193848144;
	localparam logic signed [63:0] CENTER_IMAG_RST = 64'sd566238352;
	localparam logic [62:0]        VIEW_SCALE_RST  = 63'd15032385536;

	typedef enum logic [1:0] {
		CFG_CENTER_REAL = 2'd0,
		CFG_CENTER_IMAG = 2'd1,
		CFG_VIEW_SCALE  = 2'd2
	} cfg_idx_t;

	// Request and response of the shared multiplier
	typedef struct packed {
		logic        start;
		logic [63:0] a;
		logic [63:0] b;
	} mul_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] q;   // signed Q32.32 product, bits 95..32
		logic [63:0] lo;  // integer product, bits 63..0
	} mul_rsp_t;

	// Iteration limit from the view width
	function automatic logic [COUNT_W-1:0] iter_limit(input logic [62:0] s);
		logic [31:0] lo;
		logic [COUNT_W-1:0] lim;
		lo = s[31:0];
		if (s[62:32] != 31'd0)        lim = 9'd60;
		else if (lo > 32'h4000_0000)  lim = 9'd100;
		else if (lo > 32'h1000_0000)  lim = 9'd120;
		else if (lo > 32'h0400_0000)  lim = 9'd160;
		else if (lo > 32'h0100_0000)  lim = 9'd200;
		else if (lo > 32'h0040_0000)  lim = 9'd240;
		else if (lo > 32'h0010_0000)  lim = 9'd280;
		else if (lo > 32'h0004_0000)  lim = 9'd300;
		else if (lo > 32'h0001_0000)  lim = 9'd320;
		else if (lo > 32'h0000_4000)  lim = 9'd340;
		else if (lo > 32'h0000_1000)  lim = 9'd380;
		else                          lim = 9'd410;
		return lim;
	endfunction

endpackage

// ===== design/mpe_pixel_if.sv =====
interface mpe_pixel_if;
	logic       valid;
	logic       ready;
	logic [8:0] pixel_x;
	logic [7:0] pixel_y;

	modport source(output valid, pixel_x, pixel_y, input ready);
	modport sink(input valid, pixel_x, pixel_y, output ready);
endinterface

// ===== design/mpe_result_if.sv =====
interface mpe_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] color_index;
	logic [8:0] escape_count;

	modport source(output valid, color_index, escape_count, input ready);
	modport sink(input valid, color_index, escape_count, output ready);
endinterface

// ===== design/mpe_cfg_if.sv =====
interface mpe_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [63:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== design/mpe_mul.sv =====
module mpe_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  mpe_pkg::mul_req_t req,
	output mpe_pkg::mul_rsp_t rsp
);
	import mpe_pkg::*;

	logic [63:0] a_q;
	logic [63:0] b_q;
	logic [2:0]  phase_q;
	logic        busy_q;
	logic [63:0] prod_s1;
	logic [1:0]  sh_s1;
	logic [95:0] acc_q;
	logic        done_q;
	logic [63:0] q_q;
	logic [63:0] lo_q;

	logic [31:0] a_half;
	logic [31:0] b_half;
	logic [63:0] prod;
	logic [1:0]  sh;
	logic [95:0] aligned;
	logic [31:0] corr;

	// Partial products: al*bl, al*bh, ah*bl, ah*bh
	assign a_half = phase_q[1] ? a_q[63:32] : a_q[31:0];
	assign b_half = phase_q[0] ? b_q[63:32] : b_q[31:0];
	assign prod   = 64'(a_half) * 64'(b_half);
	assign sh     = 2'(phase_q[1]) + 2'(phase_q[0]);

	always_comb begin
		case (sh_s1)
			2'd0:    aligned = {32'd0, prod_s1};
			2'd1:    aligned = {prod_s1, 32'd0};
			2'd2:    aligned = {prod_s1[31:0], 64'd0};
			default: aligned = 96'd0;
		endcase
	end

	// Signed correction touches only the upper word
	assign corr = (a_q[63] ? b_q[31:0] : 32'd0) + (b_q[63] ? a_q[31:0] : 32'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= 3'd0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (!busy_q) begin
				if (req.start) begin
					a_q     <= req.a;
					b_q     <= req.b;
					acc_q   <= 96'd0;
					phase_q <= 3'd0;
					busy_q  <= 1'b1;
				end
			end else begin
				if (phase_q < 3'd4) begin
					prod_s1 <= prod;
					sh_s1   <= sh;
				end
				if (phase_q >= 3'd1 && phase_q <= 3'd4) begin
					acc_q <= acc_q + aligned;
				end
				if (phase_q == 3'd5) begin
					q_q    <= {acc_q[95:64] - corr, acc_q[63:32]};
					lo_q   <= acc_q[63:0];
					done_q <= 1'b1;
					busy_q <= 1'b0;
				end
				phase_q <= phase_q + 3'd1;
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.q    = q_q;
	assign rsp.lo   = lo_q;

endmodule

// ===== design/mandelbrot_pixel_engine.sv =====
// Escape-time pixel engine, signed Q32.32 fixed point.
// pixel: takes one pixel_x / pixel_y word; ready is high only while the
//   engine is idle, so one pixel is worked on at a time.
// result: gives color_index and escape_count for that pixel, one word per
//   pixel, in order. The word sits in an output register, so the next pixel
//   is taken while the result still waits for the receiver.
// cfg: writes center_real (0), center_imag (1) or view_scale (2) at any
//   time ready is high (always); other indexes are dropped. Write only when
//   the engine is idle.
// Arithmetic: every product runs through one 32x32 multiplier, as four
//   partial products per Q32.32 product. Set-up of the point takes 5
//   products; each iteration takes 3 products, and at most 410 iterations
//   are run per pixel.
// If the receiver stalls, a finished result holds the engine until the
//   previous word has been taken.
// Reset restores the default view and empties the engine and output.
module mandelbrot_pixel_engine (
	input  logic          clk,
	input  logic          arst_n,
	mpe_pixel_if.sink     pixel,
	mpe_result_if.source  result,
	mpe_cfg_if.sink       cfg
);
	import mpe_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_STEP,
		ST_HALF,
		ST_HGT,
		ST_CRE,
		ST_CIM,
		ST_RR,
		ST_II,
		ST_RI,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   issued_q;

	logic [63:0] center_real_q;
	logic [63:0] center_imag_q;
	logic [62:0] view_scale_q;

	logic [8:0]  px_q;
	logic [7:0]  py_q;
	logic [63:0] step_q;
	logic [63:0] re_q;
	logic [63:0] im_q;
	logic [63:0] zre_q;
	logic [63:0] zim_q;
	logic [63:0] rr_q;
	logic [63:0] ii_q;
	logic [COUNT_W-1:0] k_q;
	logic [COUNT_W-1:0] limit_q;
	logic [COUNT_W-1:0] count_q;

	logic               res_valid_q;
	logic [COLOR_W-1:0] color_q;
	logic [COUNT_W-1:0] count_out_q;

	mul_req_t mreq;
	mul_rsp_t mrsp;

	logic [63:0]        mag;
	logic               escaped;
	logic [COUNT_W-1:0] k_next;
	logic [COUNT_W-1:0] pal_m1;
	logic [COUNT_W-1:0] pal_red;
	logic               is_mul_state;

	mpe_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rsp    (mrsp)
	);

	assign is_mul_state = (state_q != ST_IDLE) && (state_q != ST_DONE);

	always_comb begin
		mreq.start = is_mul_state && !issued_q;
		case (state_q)
			ST_STEP: begin
				mreq.a = {1'b0, view_scale_q};
				mreq.b = RECIP_WIDTH_Q;
			end
			ST_HALF: begin
				mreq.a = {1'b0, view_scale_q};
				mreq.b = HALF_Q;
			end
			ST_HGT: begin
				mreq.a = step_q;
				mreq.b = HALF_HEIGHT_Q;
			end
			ST_CRE: begin
				mreq.a = step_q;
				mreq.b = 64'(px_q);
			end
			ST_CIM: begin
				mreq.a = step_q;
				mreq.b = 64'(py_q);
			end
			ST_RR: begin
				mreq.a = zre_q;
				mreq.b = zre_q;
			end
			ST_II: begin
				mreq.a = zim_q;
				mreq.b = zim_q;
			end
			ST_RI: begin
				mreq.a = zre_q;
				mreq.b = zim_q;
			end
			default: begin
				mreq.a = 64'd0;
				mreq.b = 64'd0;
			end
		endcase
	end

	// |z|^2 is checked before the update of the same iteration
	assign mag     = rr_q + ii_q;
	assign escaped = mag[63:32] >= ESCAPE_BOUND;
	assign k_next  = k_q + 9'd1;

	// Palette: ((count - 1) mod 255) + 1, count never above twice the span
	assign pal_m1  = count_q - 9'd1;
	assign pal_red = (pal_m1 >= PALETTE_SPAN) ? pal_m1 - PALETTE_SPAN : pal_m1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			issued_q      <= 1'b0;
			res_valid_q   <= 1'b0;
			center_real_q <= CENTER_REAL_RST;
			center_imag_q <= CENTER_IMAG_RST;
			view_scale_q  <= VIEW_SCALE_RST;
		end else begin
			if (cfg.valid) begin
				case (cfg_idx_t'(cfg.index))
					CFG_CENTER_REAL: center_real_q <= cfg.data;
					CFG_CENTER_IMAG: center_imag_q <= cfg.data;
					CFG_VIEW_SCALE:  view_scale_q  <= cfg.data[62:0];
					default: ;
				endcase
			end

			if (res_valid_q && result.ready) begin
				res_valid_q <= 1'b0;
			end

			if (mreq.start) begin
				issued_q <= 1'b1;
			end

			case (state_q)
				ST_IDLE: begin
					if (pixel.valid) begin
						px_q    <= pixel.pixel_x;
						py_q    <= pixel.pixel_y;
						limit_q <= iter_limit(view_scale_q);
						state_q <= ST_STEP;
					end
				end
				ST_STEP: begin
					if (mrsp.done) begin
						step_q   <= mrsp.q;
						issued_q <= 1'b0;
						state_q  <= ST_HALF;
					end
				end
				ST_HALF: begin
					if (mrsp.done) begin
						re_q     <= center_real_q - mrsp.q;
						issued_q <= 1'b0;
						state_q  <= ST_HGT;
					end
				end
				ST_HGT: begin
					if (mrsp.done) begin
						im_q     <= center_imag_q - mrsp.q;
						issued_q <= 1'b0;
						state_q  <= ST_CRE;
					end
				end
				ST_CRE: begin
					if (mrsp.done) begin
						re_q     <= re_q + mrsp.lo;
						issued_q <= 1'b0;
						state_q  <= ST_CIM;
					end
				end
				ST_CIM: begin
					if (mrsp.done) begin
						im_q     <= im_q + mrsp.lo;
						zre_q    <= 64'd0;
						zim_q    <= 64'd0;
						k_q      <= '0;
						issued_q <= 1'b0;
						state_q  <= ST_RR;
					end
				end
				ST_RR: begin
					if (mrsp.done) begin
						rr_q     <= mrsp.q;
						issued_q <= 1'b0;
						state_q  <= ST_II;
					end
				end
				ST_II: begin
					if (mrsp.done) begin
						ii_q     <= mrsp.q;
						issued_q <= 1'b0;
						state_q  <= ST_RI;
					end
				end
				ST_RI: begin
					if (mrsp.done) begin
						issued_q <= 1'b0;
						zre_q    <= (rr_q - ii_q) + re_q;
						zim_q    <= {mrsp.q[62:0], 1'b0} + im_q;
						k_q      <= k_next;
						if (escaped) begin
							count_q <= k_next;
							state_q <= ST_DONE;
						end else if (k_next == limit_q) begin
							count_q <= '0;
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_RR;
						end
					end
				end
				ST_DONE: begin
					// hold until the output register is free
					if (!res_valid_q || result.ready) begin
						res_valid_q <= 1'b1;
						count_out_q <= count_q;
						color_q     <= (count_q == '0) ? '0 : pal_red[COLOR_W-1:0] + 8'd1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign pixel.ready         = (state_q == ST_IDLE);
	assign result.valid        = res_valid_q;
	assign result.color_index  = color_q;
	assign result.escape_count = count_out_q;
	assign cfg.ready           = 1'b1;

endmodule
